FILE: hw/rtl/gtpu_pkg.sv
// ----------------------------------------------------------------------------
// GTP-U header parser package
// Shared phase codes, field kinds, error codes and extension type constants.
// ----------------------------------------------------------------------------
package gtpu_pkg;

  // Parser phase, one code per position in the header walk.
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_FIXED     = 5'd1,
    PH_OPT       = 5'd2,
    PH_EXTLEN    = 5'd3,
    PH_EXTBODY   = 5'd4,
    PH_NEXTTYPE  = 5'd5,
    PH_C_OCT0    = 5'd6,
    PH_C_OCT1    = 5'd7,
    PH_C_DL_PPI  = 5'd8,
    PH_C_DL_TS   = 5'd9,
    PH_C_DL_SEQ  = 5'd10,
    PH_C_UL_TS1  = 5'd11,
    PH_C_UL_TS2  = 5'd12,
    PH_C_UL_TS3  = 5'd13,
    PH_C_UL_DLD  = 5'd14,
    PH_C_UL_ULD  = 5'd15,
    PH_C_UL_SEQ  = 5'd16,
    PH_SKIP      = 5'd17,
    PH_PAYLOAD   = 5'd18
  } phase_e;

  // Field kinds of a result.
  localparam logic [4:0] K_MSGTYPE  = 5'd0;
  localparam logic [4:0] K_TEID     = 5'd1;
  localparam logic [4:0] K_SEQ      = 5'd2;
  localparam logic [4:0] K_NPDU     = 5'd3;
  localparam logic [4:0] K_UDPPORT  = 5'd4;
  localparam logic [4:0] K_PDCP     = 5'd5;
  localparam logic [4:0] K_LONGPDCP = 5'd6;
  localparam logic [4:0] K_PDUTYPE  = 5'd7;
  localparam logic [4:0] K_QMP      = 5'd8;
  localparam logic [4:0] K_QFI      = 5'd9;
  localparam logic [4:0] K_RQI      = 5'd10;
  localparam logic [4:0] K_PPI      = 5'd11;
  localparam logic [4:0] K_PAYLOAD  = 5'd20;
  localparam logic [4:0] K_ERROR    = 5'd21;

  // Error codes.
  localparam logic [63:0] E_VERSION  = 64'd0;
  localparam logic [63:0] E_PROTO    = 64'd1;
  localparam logic [63:0] E_EXTTYPE  = 64'd2;
  localparam logic [63:0] E_PDUTYPE  = 64'd3;
  localparam logic [63:0] E_LENGTH   = 64'd4;

  // Extension header types.
  localparam logic [7:0] EXT_UDPPORT  = 8'h40;
  localparam logic [7:0] EXT_LONGPDCP = 8'h82;
  localparam logic [7:0] EXT_RANCONT  = 8'h84;
  localparam logic [7:0] EXT_PDUSESS  = 8'h85;
  localparam logic [7:0] EXT_PDCP     = 8'hC0;
  localparam logic [7:0] EXT_UNUSED1  = 8'h81;
  localparam logic [7:0] EXT_UNUSED2  = 8'h83;

  // Results one input byte can cause.
  localparam int unsigned MaxRes = 3;

  // One result.
  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic        run_last;
    logic        pkt_end;
  } result_t;

endpackage

FILE: hw/rtl/gtpu_header_parser_top.sv
// ----------------------------------------------------------------------------
// GTP-U v1 header parser
// Byte-wide parser that turns a GTP-U packet into field kind/value results.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one packet octet per request in tdata, with tuser
// high on the first octet of a packet. The master channel returns decoded
// fields: tdata is the 64-bit value, tuser holds the field kind and the mark
// for the last result of an input octet, tlast flags the final payload octet
// or an error result.
// Each accepted octet is decoded in the cycle it is taken, and its zero to
// three results are loaded into a result buffer; the first result is shown
// the next cycle. One octet per cycle is sustained while each octet gives at
// most one result and the receiver is ready; an octet giving more results
// holds off the input while the single output port drains the buffer.
// Reset returns the parser to waiting for a packet start and empties the
// buffer. When the receiver stalls, the buffer holds its results and the
// input is held off once the last buffered result cannot leave this cycle.
// ----------------------------------------------------------------------------
module gtpu_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] field_value
  output logic [5:0]  m_axis_tuser,   // [4:0] field_kind, [5] run_last
  output logic        m_axis_tlast    // packet_end
);
  import gtpu_pkg::*;

  // Parser state.
  phase_e       ph_q, ph_d;
  logic [3:0]   bif_q, bif_d;
  logic [63:0]  acc_q, acc_d;
  logic [2:0]   hf_q, hf_d;
  logic [15:0]  dl_q, dl_d;
  logic [16:0]  baf_q, baf_d;
  logic [7:0]   et_q, et_d;
  logic [9:0]   ebl_q, ebl_d;
  logic [5:0]   cf_q, cf_d;
  logic [9:0]   cbr_q, cbr_d;

  // Result buffer.
  result_t      buf_q [MaxRes];
  result_t      res   [4];
  logic [1:0]   cnt_q, pos_q;
  logic [2:0]   n_res;
  logic         in_acc, out_acc;

  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (pos_q != cnt_q);
  assign s_axis_tready = (pos_q == cnt_q) ||
                         ((pos_q + 2'd1 == cnt_q) && m_axis_tready);
  assign m_axis_tdata  = buf_q[pos_q].value;
  assign m_axis_tuser  = {buf_q[pos_q].run_last, buf_q[pos_q].kind};
  assign m_axis_tlast  = buf_q[pos_q].pkt_end;

  // Container field present under the current container flags.
  function automatic logic present(input phase_e p, input logic [5:0] f);
    logic ul;
    ul = f[5];
    unique case (p)
      PH_C_DL_PPI:                          return !ul && f[4];
      PH_C_DL_TS:                           return !ul && f[3];
      PH_C_DL_SEQ:                          return !ul && f[0];
      PH_C_UL_TS1, PH_C_UL_TS2, PH_C_UL_TS3: return ul && f[3];
      PH_C_UL_DLD:                          return ul && f[2];
      PH_C_UL_ULD:                          return ul && f[1];
      PH_C_UL_SEQ:                          return ul && f[0];
      default:                              return 1'b0;
    endcase
  endfunction

  // Octets in a container field.
  function automatic logic [3:0] flen(input phase_e p);
    priority if (p == PH_C_DL_PPI) return 4'd1;
    else if (p == PH_C_DL_SEQ || p == PH_C_UL_SEQ) return 4'd3;
    else if (p == PH_C_UL_DLD || p == PH_C_UL_ULD) return 4'd4;
    else return 4'd8;
  endfunction

  // Per-octet decode of the header walk.
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  nph;
    logic        hdr;
    logic        is_ext;
    logic [63:0] sh;
    b      = s_axis_tdata;
    ph_d   = ph_q;  bif_d = bif_q; acc_d = acc_q; hf_d = hf_q; dl_d = dl_q;
    baf_d  = baf_q; et_d  = et_q;  ebl_d = ebl_q; cf_d = cf_q; cbr_d = cbr_q;
    n_res  = 3'd0;
    nph    = 5'(PH_SKIP);
    hdr    = 1'b0;
    sh     = {acc_q[55:0], b};
    is_ext = 1'b0;
    for (int i = 0; i < 4; i++) res[i] = '0;

    if (s_axis_tuser) begin
      // Packet start: clear everything and check the flags octet.
      ph_d = PH_IDLE; bif_d = '0; acc_d = '0; hf_d = '0; dl_d = '0;
      baf_d = '0; et_d = '0; ebl_d = '0; cf_d = '0; cbr_d = '0;
      if (b[7:5] != 3'd1) begin
        res[0] = '{K_ERROR, E_VERSION, 1'b0, 1'b1}; n_res = 3'd1;
      end else if (!b[4]) begin
        res[0] = '{K_ERROR, E_PROTO, 1'b0, 1'b1}; n_res = 3'd1;
      end else begin
        hf_d = b[2:0]; ph_d = PH_FIXED; bif_d = 4'd1;
      end
    end else if (ph_q == PH_FIXED) begin
      // Fixed 8-octet header.
      if (bif_q == 4'd1) begin
        res[0] = '{K_MSGTYPE, {56'd0, b}, 1'b0, 1'b0}; n_res = 3'd1;
      end else if (bif_q == 4'd2) begin
        dl_d = {b, 8'd0};
      end else if (bif_q == 4'd3) begin
        dl_d = {dl_q[15:8], b};
      end else begin
        acc_d = sh;
      end
      bif_d = bif_q + 4'd1;
      if (bif_q >= 4'd7) begin
        res[n_res[1:0]] = '{K_TEID, {32'd0, acc_d[31:0]}, 1'b0, 1'b0};
        n_res = n_res + 3'd1;
        bif_d = '0; acc_d = '0;
        if (hf_q != 3'd0) ph_d = PH_OPT;
        else ph_d = (baf_q >= {1'b0, dl_q}) ? PH_IDLE : PH_PAYLOAD;
      end
    end else if (ph_q == PH_PAYLOAD) begin
      // Payload octets.
      baf_d = baf_q + 17'd1;
      res[0] = '{K_PAYLOAD, {56'd0, b}, 1'b0, baf_d >= {1'b0, dl_q}};
      n_res = 3'd1;
      if (baf_d >= {1'b0, dl_q}) ph_d = PH_IDLE;
    end else if (ph_q >= PH_OPT && ph_q <= PH_SKIP) begin
      hdr = 1'b1;
    end

    if (hdr) begin
      if (baf_q >= {1'b0, dl_q}) begin
        res[0] = '{K_ERROR, E_LENGTH, 1'b0, 1'b1}; n_res = 3'd1;
        ph_d = PH_IDLE;
      end else begin
        baf_d = baf_q + 17'd1;
        unique case (ph_q)
          PH_OPT: begin
            // Sequence, N-PDU and next-type word.
            if (bif_q == 4'd0) begin
              acc_d = {56'd0, b};
            end else if (bif_q == 4'd1) begin
              acc_d = sh;
              if (hf_q[1]) begin
                res[0] = '{K_SEQ, {48'd0, sh[15:0]}, 1'b0, 1'b0}; n_res = 3'd1;
              end
            end else if (bif_q == 4'd2) begin
              if (hf_q[0]) begin
                res[0] = '{K_NPDU, {56'd0, b}, 1'b0, 1'b0}; n_res = 3'd1;
              end
            end else begin
              if (hf_q[2]) is_ext = 1'b1;
              else ph_d = (baf_d >= {1'b0, dl_q}) ? PH_IDLE : PH_PAYLOAD;
            end
            bif_d = bif_q + 4'd1;
          end
          PH_NEXTTYPE: is_ext = 1'b1;
          PH_EXTLEN: begin
            // Extension length in 4-octet units.
            if (b == 8'd0) begin
              res[0] = '{K_ERROR, E_LENGTH, 1'b0, 1'b1}; n_res = 3'd1;
              ph_d = PH_IDLE;
            end else begin
              ebl_d = {b, 2'b00} - 10'd2;
              cbr_d = '0; bif_d = '0; acc_d = '0; cf_d = '0;
              if (et_q == EXT_PDUSESS) ph_d = PH_C_OCT0;
              else if (((et_q == EXT_UDPPORT || et_q == EXT_PDCP) && b == 8'd1) ||
                       (et_q == EXT_LONGPDCP && b == 8'd2)) ph_d = PH_EXTBODY;
              else ph_d = PH_SKIP;
            end
          end
          default: begin
            // Extension content.
            if (ph_q == PH_EXTBODY) begin
              acc_d = sh;
              bif_d = bif_q + 4'd1;
              if (bif_d >= ((et_q == EXT_LONGPDCP) ? 4'd3 : 4'd2)) begin
                if (et_q == EXT_LONGPDCP)
                  res[0] = '{K_LONGPDCP, {46'd0, sh[17:0]}, 1'b0, 1'b0};
                else
                  res[0] = '{(et_q == EXT_UDPPORT) ? K_UDPPORT : K_PDCP,
                             {48'd0, sh[15:0]}, 1'b0, 1'b0};
                n_res = 3'd1;
                ph_d = PH_SKIP;
              end
            end else if (ph_q == PH_C_OCT0) begin
              if (b[7:4] > 4'd1) begin
                res[0] = '{K_ERROR, E_PDUTYPE, 1'b0, 1'b1}; n_res = 3'd1;
                ph_d = PH_IDLE;
              end else begin
                if (b[7:4] == 4'd0) cf_d = {2'b00, b[3], 2'b00, b[2]};
                else cf_d = {2'b10, b[3:0]};
                res[0] = '{K_PDUTYPE, {60'd0, b[7:4]}, 1'b0, 1'b0};
                res[1] = '{K_QMP, {63'd0, b[3]}, 1'b0, 1'b0};
                n_res = 3'd2;
                ph_d = PH_C_OCT1;
              end
            end else if (ph_q == PH_C_OCT1) begin
              res[0] = '{K_QFI, {58'd0, b[5:0]}, 1'b0, 1'b0}; n_res = 3'd1;
              if (!cf_q[5]) begin
                res[1] = '{K_RQI, {63'd0, b[6]}, 1'b0, 1'b0}; n_res = 3'd2;
                if (b[7]) cf_d = cf_q | 6'h10;
              end
              for (int p = int'(PH_C_UL_SEQ); p >= int'(PH_C_DL_PPI); p--)
                if (present(phase_e'(p), cf_d)) nph = 5'(p);
              bif_d = '0; acc_d = '0; ph_d = phase_e'(nph);
            end else if (ph_q == PH_C_DL_PPI) begin
              res[0] = '{K_PPI, {61'd0, b[7:5]}, 1'b0, 1'b0}; n_res = 3'd1;
              for (int p = int'(PH_C_UL_SEQ); p >= int'(PH_C_DL_TS); p--)
                if (present(phase_e'(p), cf_q)) nph = 5'(p);
              bif_d = '0; acc_d = '0; ph_d = phase_e'(nph);
            end else if (ph_q >= PH_C_DL_TS && ph_q <= PH_C_UL_SEQ) begin
              acc_d = sh;
              bif_d = bif_q + 4'd1;
              if (bif_d >= flen(ph_q)) begin
                res[0] = '{5'(ph_q) + 5'd3, sh, 1'b0, 1'b0}; n_res = 3'd1;
                for (int p = int'(PH_C_UL_SEQ); p >= int'(PH_C_DL_TS); p--)
                  if (5'(p) > 5'(ph_q) && present(phase_e'(p), cf_q)) nph = 5'(p);
                bif_d = '0; acc_d = '0; ph_d = phase_e'(nph);
              end
            end
            // Extension octet count.
            if (ph_d != PH_IDLE) begin
              ebl_d = ebl_q - 10'd1;
              cbr_d = cbr_q + 10'd1;
              if (ebl_d == 10'd0) begin
                if (ph_d == PH_SKIP) begin
                  ph_d = PH_NEXTTYPE;
                end else begin
                  res[n_res[1:0]] = '{K_ERROR, E_LENGTH, 1'b0, 1'b1};
                  n_res = n_res + 3'd1;
                  ph_d = PH_IDLE;
                end
              end
            end
          end
        endcase
        // Start of the next extension header.
        if (is_ext) begin
          if (b == 8'd0) begin
            ph_d = (baf_d >= {1'b0, dl_q}) ? PH_IDLE : PH_PAYLOAD;
          end else if (b == EXT_UDPPORT || b == EXT_LONGPDCP || b == EXT_RANCONT ||
                       b == EXT_PDUSESS || b == EXT_PDCP || b == EXT_UNUSED1 ||
                       b == EXT_UNUSED2) begin
            et_d = b; ph_d = PH_EXTLEN;
          end else begin
            res[n_res[1:0]] = '{K_ERROR, E_EXTTYPE, 1'b0, 1'b1};
            n_res = n_res + 3'd1;
            ph_d = PH_IDLE;
          end
        end
      end
    end

    if (n_res != 3'd0) res[n_res[1:0] - 2'd1].run_last = 1'b1;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; bif_q <= '0; acc_q <= '0; hf_q <= '0; dl_q <= '0;
      baf_q <= '0; et_q <= '0; ebl_q <= '0; cf_q <= '0; cbr_q <= '0;
    end else if (in_acc) begin
      ph_q <= ph_d; bif_q <= bif_d; acc_q <= acc_d; hf_q <= hf_d; dl_q <= dl_d;
      baf_q <= baf_d; et_q <= et_d; ebl_q <= ebl_d; cf_q <= cf_d; cbr_q <= cbr_d;
    end
  end

  // Result buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else if (in_acc) begin
      cnt_q <= n_res[1:0];
      pos_q <= '0;
    end else if (out_acc) begin
      pos_q <= pos_q + 2'd1;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) buf_q[i] <= res[i];
    end
  end

  // Checks.
  a_pos_le_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cnt_q) else $error("read position beyond buffered results");
  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty buffer");
  a_idle_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ph_q == PH_IDLE && !s_axis_tuser |=> !m_axis_tvalid)
    else $error("result produced while idle");
  a_end_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[5])
    else $error("packet end not on last result of an octet");
endmodule
